@@ src/uutp_pkg.sv @@
// ----------------------------------------------------------------------------
// uutp_pkg
// Shared constants and types for the UUID text parser.
// ----------------------------------------------------------------------------
package uutp_pkg;

	localparam int unsigned UUID_LEN = 36;
	localparam int unsigned POS_SAT  = 37;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned NIB_W    = 4;
	localparam int unsigned HALF_W   = 64;
	localparam int unsigned ACC_W    = 2 * HALF_W;
	localparam int unsigned OUT_W    = 136;

	localparam logic [POS_W-1:0] POS_DASH0   = POS_W'(8);
	localparam logic [POS_W-1:0] POS_DASH1   = POS_W'(13);
	localparam logic [POS_W-1:0] POS_DASH2   = POS_W'(18);
	localparam logic [POS_W-1:0] POS_DASH3   = POS_W'(23);
	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(14);
	localparam logic [POS_W-1:0] POS_LEN     = POS_W'(UUID_LEN);
	localparam logic [POS_W-1:0] POS_MAX     = POS_W'(POS_SAT);

	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
	localparam logic [CHAR_W-1:0] CH_5     = 8'h35;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] HEX_TEN  = 8'h0a;

	typedef struct packed {
		logic             pack;
		logic             bad;
		logic [NIB_W-1:0] nib;
	} uutp_dec_t;

endpackage

@@ src/uutp_char_decode.sv @@
// ----------------------------------------------------------------------------
// uutp_char_decode
// Checks one character against the format at its position and gives its nibble.
// ----------------------------------------------------------------------------
module uutp_char_decode (
	input  logic [uutp_pkg::CHAR_W-1:0] char_code,
	input  logic [uutp_pkg::POS_W-1:0]  position,
	output uutp_pkg::uutp_dec_t         dec
);

	logic                        in_range;
	logic                        dash_slot;
	logic                        is_digit;
	logic                        is_upper;
	logic                        is_lower;
	logic                        hex_ok;
	logic                        ok;
	logic [uutp_pkg::CHAR_W-1:0] hex_val;

	assign in_range  = position < uutp_pkg::POS_LEN;
	assign dash_slot = (position == uutp_pkg::POS_DASH0) || (position == uutp_pkg::POS_DASH1) ||
		(position == uutp_pkg::POS_DASH2) || (position == uutp_pkg::POS_DASH3);

	assign is_digit = (char_code >= uutp_pkg::CH_0) && (char_code <= uutp_pkg::CH_9);
	assign is_upper = (char_code >= uutp_pkg::CH_UA) && (char_code <= uutp_pkg::CH_UF);
	assign is_lower = (char_code >= uutp_pkg::CH_LA) && (char_code <= uutp_pkg::CH_LF);
	assign hex_ok   = is_digit || is_upper || is_lower;

	always_comb begin
		if (is_digit) begin
			hex_val = char_code - uutp_pkg::CH_0;
		end else if (is_lower) begin
			hex_val = char_code - uutp_pkg::CH_LA + uutp_pkg::HEX_TEN;
		end else begin
			hex_val = char_code - uutp_pkg::CH_UA + uutp_pkg::HEX_TEN;
		end
	end

	// version slot allows only '1' to '5'
	assign ok = (position == uutp_pkg::POS_VERSION) ?
		((char_code >= uutp_pkg::CH_1) && (char_code <= uutp_pkg::CH_5)) : hex_ok;

	always_comb begin
		dec.pack = 1'b0;
		dec.bad  = 1'b0;
		dec.nib  = '0;
		if (in_range) begin
			if (dash_slot) begin
				dec.bad = (char_code != uutp_pkg::CH_DASH);
			end else begin
				dec.pack = 1'b1;
				dec.bad  = !ok;
				dec.nib  = ok ? hex_val[uutp_pkg::NIB_W-1:0] : '0;
			end
		end
	end

endmodule

@@ src/uuid_text_parser.sv @@
// ----------------------------------------------------------------------------
// uuid_text_parser
// Parses a 36-character UUID string into a 128-bit identifier.
// ----------------------------------------------------------------------------
// usage:
//   characters enter on the s_axis channel, one per transfer, with tlast on the
//   final character of each string. only the final character produces a
//   transfer on m_axis: a valid flag and the identifier as two 64-bit halves,
//   both zero when the format or the length is wrong.
// path: a final character passes the input register, then the result register,
//   before its result is presented on m_axis.
// throughput: one character per cycle outside a stall; the per-character check
//   and the nibble shift into the 128-bit accumulator sit in one short stage.
// reset: arst_n clears the position count, error flag, accumulator and both
//   stage valids; parsing starts with a fresh string.
// stall: a held result keeps its register; non-final characters still drain,
//   a final character waits in the input register until the result register
//   frees, and s_axis_tready is low only while it waits.
// ----------------------------------------------------------------------------
module uuid_text_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // char_code
	input  logic                         s_axis_tlast,  // last_char
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [uutp_pkg::OUT_W-1:0]   m_axis_tdata   // valid_res, id_high, id_low
);

	logic                          valid_s1;
	logic [uutp_pkg::CHAR_W-1:0]   char_s1;
	logic                          last_s1;

	logic [uutp_pkg::POS_W-1:0]    pos_q;
	logic                          err_q;
	logic [uutp_pkg::ACC_W-1:0]    acc_q;

	logic                          out_valid_q;
	logic [uutp_pkg::OUT_W-1:0]    out_data_q;

	uutp_pkg::uutp_dec_t           dec;
	logic                          out_free;
	logic                          advance;
	logic [uutp_pkg::POS_W-1:0]    pos_next;
	logic                          err_next;
	logic [uutp_pkg::ACC_W-1:0]    acc_next;
	logic                          res_ok;

	uutp_char_decode u_decode (
		.char_code (char_s1),
		.position  (pos_q),
		.dec       (dec)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	assign pos_next = (pos_q == uutp_pkg::POS_MAX) ? pos_q : pos_q + uutp_pkg::POS_W'(1);
	assign err_next = err_q || dec.bad;
	assign acc_next = dec.pack ?
		{acc_q[uutp_pkg::ACC_W-uutp_pkg::NIB_W-1:0], dec.nib} : acc_q;
	assign res_ok   = !err_next && (pos_next == uutp_pkg::POS_LEN);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
			acc_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q <= '0;
				err_q <= 1'b0;
				acc_q <= '0;
			end else begin
				pos_q <= pos_next;
				err_q <= err_next;
				acc_q <= acc_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= {
				(uutp_pkg::OUT_W - uutp_pkg::ACC_W - 1)'(0),
				res_ok ? acc_next[uutp_pkg::HALF_W-1:0] : uutp_pkg::HALF_W'(0),
				res_ok ? acc_next[uutp_pkg::ACC_W-1:uutp_pkg::HALF_W] : uutp_pkg::HALF_W'(0),
				res_ok
			};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams UUID strings into uuid_text_parser and checks each parsed result.
// ----------------------------------------------------------------------------
// Well-formed strings, single-character corruptions, wrong lengths and byte
// noise are sent one character per transfer with random gaps, while the
// result side stalls at random. A local parser tracks position, format error
// and the nibble accumulator for every accepted character. Each result is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int IDLE_LIMIT  = 1000;
	localparam int ITEM_TARGET = 1750;

	typedef struct packed {
		logic                        ok;
		logic [uutp_pkg::HALF_W-1:0] hi;
		logic [uutp_pkg::HALF_W-1:0] lo;
	} parsed_id_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata = '0;
	logic                        s_axis_tlast = 1'b0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [uutp_pkg::OUT_W-1:0]  m_axis_tdata;

	// parser state as seen from the character stream
	logic [uutp_pkg::POS_W-1:0]  str_pos = '0;
	logic                        str_bad = 1'b0;
	logic [uutp_pkg::HALF_W-1:0] acc_hi = '0;
	logic [uutp_pkg::HALF_W-1:0] acc_lo = '0;

	parsed_id_t        expected_ids[$];
	logic [7:0]        text_buf[$];
	int                mismatches = 0;
	int                chars_sent = 0;
	int                idle_cycles = 0;
	int                rx_wait = 0;
	logic              no_gaps = 1'b0;
	logic              rx_calm = 1'b0;

	uuid_text_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// {ok, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		if (c >= uutp_pkg::CH_0 && c <= uutp_pkg::CH_9) begin
			return {1'b1, 4'(c - uutp_pkg::CH_0)};
		end else if (c >= uutp_pkg::CH_LA && c <= uutp_pkg::CH_LF) begin
			return {1'b1, 4'(c - uutp_pkg::CH_LA + uutp_pkg::HEX_TEN)};
		end else if (c >= uutp_pkg::CH_UA && c <= uutp_pkg::CH_UF) begin
			return {1'b1, 4'(c - uutp_pkg::CH_UA + uutp_pkg::HEX_TEN)};
		end
		return 5'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10) begin
			return uutp_pkg::CH_0 + 8'(v);
		end
		return (upper ? uutp_pkg::CH_UA : uutp_pkg::CH_LA) + 8'(v) - uutp_pkg::HEX_TEN;
	endfunction

	function automatic logic is_dash_pos(input int p);
		return p == int'(uutp_pkg::POS_DASH0) || p == int'(uutp_pkg::POS_DASH1) ||
			p == int'(uutp_pkg::POS_DASH2) || p == int'(uutp_pkg::POS_DASH3);
	endfunction

	// characters just outside the hex ranges, plus 'Z' and 'z'
	function automatic logic [7:0] near_hex(input int idx);
		case (idx)
			0: return uutp_pkg::CH_0 - 8'd1;
			1: return uutp_pkg::CH_9 + 8'd1;
			2: return uutp_pkg::CH_UA - 8'd1;
			3: return uutp_pkg::CH_UF + 8'd1;
			4: return uutp_pkg::CH_LA - 8'd1;
			5: return uutp_pkg::CH_LF + 8'd1;
			6: return uutp_pkg::CH_UA + 8'd25;
			default: return uutp_pkg::CH_LA + 8'd25;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic parse_char(input logic [7:0] c, input logic fin);
		logic [4:0] dec;
		parsed_id_t r;
		if (str_pos < uutp_pkg::POS_LEN) begin
			if (is_dash_pos(int'(str_pos))) begin
				if (c != uutp_pkg::CH_DASH) str_bad = 1'b1;
			end else begin
				dec = hex_decode(c);
				if (str_pos == uutp_pkg::POS_VERSION)
					dec[4] = c >= uutp_pkg::CH_1 && c <= uutp_pkg::CH_5;
				if (!dec[4]) begin
					str_bad = 1'b1;
					dec[3:0] = '0;
				end
				{acc_hi, acc_lo} = {acc_hi[uutp_pkg::HALF_W-5:0], acc_lo, dec[3:0]};
			end
		end
		if (str_pos < uutp_pkg::POS_MAX) str_pos = str_pos + 1'b1;
		if (fin) begin
			r.ok = !str_bad && str_pos == uutp_pkg::POS_LEN;
			r.hi = r.ok ? acc_hi : '0;
			r.lo = r.ok ? acc_lo : '0;
			expected_ids.push_back(r);
			str_pos = '0;
			str_bad = 1'b0;
			acc_hi = '0;
			acc_lo = '0;
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = no_gaps ? 0 : int'($urandom_range(0, 3));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		parse_char(c, fin);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_buf[i]) begin
			send_char(text_buf[i], i == text_buf.size() - 1);
		end
	endtask

	task automatic pick_pace();
		no_gaps = $urandom_range(0, 5) == 0;
		rx_calm = $urandom_range(0, 5) == 0;
	endtask

	task automatic load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	task automatic new_uuid();
		text_buf.delete();
		for (int p = 0; p < int'(uutp_pkg::UUID_LEN); p++) begin
			if (is_dash_pos(p)) begin
				text_buf.push_back(uutp_pkg::CH_DASH);
			end else if (p == int'(uutp_pkg::POS_VERSION)) begin
				text_buf.push_back(uutp_pkg::CH_1 + 8'($urandom_range(0, 4)));
			end else begin
				text_buf.push_back(hex_char(4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
			end
		end
	endtask

	function automatic int hex_slot();
		int p;
		do p = int'($urandom_range(0, uutp_pkg::UUID_LEN - 1));
		while (is_dash_pos(p) || p == int'(uutp_pkg::POS_VERSION));
		return p;
	endfunction

	task automatic test_directed();
		text_buf = '{8'h00};
		send_text();
		text_buf = '{8'hff};
		send_text();
		load_text("0123abcd-ef45-1678-9ABC-DEF0fedc5a98");
		send_text();
	endtask

	task automatic test_valid_uuids();
		repeat (20) begin
			pick_pace();
			new_uuid();
			send_text();
		end
	endtask

	task automatic test_corrupt_uuids();
		int v;
		repeat (16) begin
			pick_pace();
			new_uuid();
			case ($urandom_range(0, 3))
				0: begin
					// version digit outside 1 to 5
					v = int'($urandom_range(0, 10));
					v = v == 0 ? 0 : v + 5;
					text_buf[uutp_pkg::POS_VERSION] =
						hex_char(4'(v), 1'($urandom_range(0, 1)));
				end
				1: begin
					case ($urandom_range(0, 3))
						0: v = int'(uutp_pkg::POS_DASH0);
						1: v = int'(uutp_pkg::POS_DASH1);
						2: v = int'(uutp_pkg::POS_DASH2);
						default: v = int'(uutp_pkg::POS_DASH3);
					endcase
					text_buf[v] = 8'($urandom_range(0, 255));
					if (text_buf[v] == uutp_pkg::CH_DASH)
						text_buf[v] = hex_char(4'($urandom), 1'b0);
				end
				2: text_buf[hex_slot()] = near_hex(int'($urandom_range(0, 7)));
				default: text_buf[$urandom_range(0, uutp_pkg::UUID_LEN - 1)] =
					8'($urandom_range(0, 255));
			endcase
			send_text();
		end
	endtask

	task automatic test_wrong_lengths();
		repeat (10) begin
			pick_pace();
			new_uuid();
			if ($urandom_range(0, 1)) begin
				repeat ($urandom_range(1, uutp_pkg::UUID_LEN - 1))
					void'(text_buf.pop_back());
			end else begin
				repeat ($urandom_range(1, 10)) text_buf.push_back(8'($urandom_range(0, 255)));
			end
			send_text();
		end
		// a wrapping position count would see 36 again here
		pick_pace();
		new_uuid();
		repeat (64) text_buf.push_back(hex_char(4'($urandom), 1'b0));
		send_text();
	endtask

	task automatic test_noise();
		while (chars_sent < ITEM_TARGET) begin
			pick_pace();
			if ($urandom_range(0, 2) == 0) begin
				new_uuid();
			end else begin
				text_buf.delete();
				repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
			end
			send_text();
		end
	endtask

	always @(negedge clk) begin
		if (rx_wait > 0) begin
			m_axis_tready <= 1'b0;
			rx_wait = rx_wait - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		parsed_id_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_ids.size() == 0) begin
				report_mismatch("result with no string pending");
			end else begin
				e = expected_ids.pop_front();
				if (m_axis_tdata[0] !== e.ok)
					report_mismatch($sformatf("valid_res got %b exp %b",
						m_axis_tdata[0], e.ok));
				if (m_axis_tdata[64:1] !== e.hi)
					report_mismatch($sformatf("id_high got %h exp %h",
						m_axis_tdata[64:1], e.hi));
				if (m_axis_tdata[128:65] !== e.lo)
					report_mismatch($sformatf("id_low got %h exp %h",
						m_axis_tdata[128:65], e.lo));
			end
			rx_wait = rx_calm ? 0 : int'($urandom_range(0, 3));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_valid_uuids();
		test_corrupt_uuids();
		test_wrong_lengths();
		test_noise();
		s_axis_tvalid <= 1'b0;
		while (expected_ids.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/uutp_pkg.sv
src/uutp_char_decode.sv
src/uuid_text_parser.sv
sim/testbench.sv
